// File: src/thpr_pkg.sv
// ============================================================================
// thpr_pkg
// shared constants, codes and types of the two-hop path resolver
// ============================================================================
package thpr_pkg;

    localparam int MAX_EDGES = 256;
    localparam int IDX_W     = $clog2(MAX_EDGES);
    localparam int CNT_W     = $clog2(MAX_EDGES + 1);
    localparam int ID_W      = 16;
    localparam int SCORE_W   = 16;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 3;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_UNRESOLVED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RESOLVED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CONFLICT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STORED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]    subject;
        logic [ID_W-1:0]    predicate;
        logic [ID_W-1:0]    object;
        logic [ID_W-1:0]    tag;
        logic [SCORE_W-1:0] authority;
        logic [SCORE_W-1:0] confidence;
        logic               active;
    } t_edge;

    localparam int EDGE_W = $bits(t_edge);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     answer_id;
        logic [ID_W-1:0]     via_id;
        logic [ID_W-1:0]     first_evidence;
        logic [ID_W-1:0]     second_evidence;
        logic [SCORE_W-1:0]  path_score;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH_I,
        S_CHECK_I,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// File: src/thpr_req_if.sv
// ============================================================================
// thpr_req_if
// request channel: valid/ready handshake with one request word
// ============================================================================
interface thpr_req_if import thpr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [ID_W-1:0]     subject_id;
    logic [ID_W-1:0]     predicate_id;
    logic [ID_W-1:0]     object_id;
    logic [ID_W-1:0]     memory_tag;
    logic                active;
    logic [SCORE_W-1:0]  authority;
    logic [SCORE_W-1:0]  confidence;

    modport source (
        output valid, req_type, subject_id, predicate_id, object_id, memory_tag,
               active, authority, confidence,
        input  ready
    );
    modport sink (
        input  valid, req_type, subject_id, predicate_id, object_id, memory_tag,
               active, authority, confidence,
        output ready
    );
endinterface

// File: src/thpr_rsp_if.sv
// ============================================================================
// thpr_rsp_if
// response channel: valid/ready handshake with one result word
// ============================================================================
interface thpr_rsp_if import thpr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     answer_id;
    logic [ID_W-1:0]     via_id;
    logic [ID_W-1:0]     first_evidence;
    logic [ID_W-1:0]     second_evidence;
    logic [SCORE_W-1:0]  path_score;

    modport source (
        output valid, status, answer_id, via_id, first_evidence, second_evidence,
               path_score,
        input  ready
    );
    modport sink (
        input  valid, status, answer_id, via_id, first_evidence, second_evidence,
               path_score,
        output ready
    );
endinterface

// File: src/two_hop_path_resolver.sv
// ============================================================================
// two_hop_path_resolver
// edge table with clear, append and best two-hop path query
// ============================================================================
// usage
//   i_req carries one request word per handshake: clear table, append edge or
//   query (subject, predicate). o_rsp returns exactly one result word per
//   request, in request order.
//   clear, append, unknown codes and queries with an empty key or an empty
//   table answer in the cycle after acceptance.
//   a query walks the edge table from a single ram port: it checks each first
//   hop candidate in turn and, for every first hop that matches subject and
//   predicate, scans every stored edge as a second hop.
//   one request is in flight at a time; the next is taken once the result
//   register is empty or being emptied in the same cycle.
//   reset empties the table count and drops any pending result; edge ram
//   contents are not cleared and are never used beyond the stored count.
//   when the receiver stalls, the result word holds and i_req.ready stays
//   low until it is taken.
// ============================================================================
module two_hop_path_resolver import thpr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    thpr_req_if.sink   i_req,
    thpr_rsp_if.source o_rsp
);

    // control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_total, n_total;
    logic               r_out_valid, n_out_valid;

    // query datapath
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [ID_W-1:0]    r_key_subj, n_key_subj;
    logic [ID_W-1:0]    r_key_pred, n_key_pred;
    logic [ID_W-1:0]    r_i_obj, n_i_obj;
    logic [ID_W-1:0]    r_i_tag, n_i_tag;
    logic [SCORE_W-1:0] r_i_min, n_i_min;
    logic               r_found, n_found;
    logic               r_conflict, n_conflict;
    logic [SCORE_W-1:0] r_best, n_best;
    logic [ID_W-1:0]    r_ans, n_ans;
    logic [ID_W-1:0]    r_via, n_via;
    logic [ID_W-1:0]    r_m1, n_m1;
    logic [ID_W-1:0]    r_m2, n_m2;
    t_rsp               r_out, n_out;

    // ram port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [EDGE_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [EDGE_W-1:0]  ram_rdata;

    t_edge              wr_edge;
    t_edge              rd;
    logic               rd_usable;
    logic               hit_i;
    logic               hit_j;
    logic [SCORE_W-1:0] j_min;
    logic [SCORE_W-1:0] score;
    logic               last_i;
    logic               last_j;
    logic               out_free;
    logic               req_ready;

    // edge table: one record per ram word
    thpr_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        wr_edge.subject    = i_req.subject_id;
        wr_edge.predicate  = i_req.predicate_id;
        wr_edge.object     = i_req.object_id;
        wr_edge.tag        = i_req.memory_tag;
        wr_edge.authority  = i_req.authority;
        wr_edge.confidence = i_req.confidence;
        wr_edge.active     = i_req.active;
    end

    assign ram_wdata = EDGE_W'(wr_edge);
    assign ram_waddr = r_total[IDX_W-1:0];
    assign rd        = t_edge'(ram_rdata);

    // an edge only counts when active with nonempty subject, predicate, object
    assign rd_usable = rd.active && (rd.subject != '0) && (rd.predicate != '0)
                       && (rd.object != '0);

    // first hop leaves the query subject on the query predicate
    assign hit_i = rd_usable && (rd.subject == r_key_subj) && (rd.predicate == r_key_pred);

    // second hop continues from the first hop's end, never back to the subject
    assign hit_j = rd_usable && (rd.subject == r_i_obj) && (rd.predicate == r_key_pred)
                   && (rd.object != r_key_subj);

    assign j_min = (rd.authority < rd.confidence) ? rd.authority : rd.confidence;
    assign score = (r_i_min < j_min) ? r_i_min : j_min;

    assign last_i   = (CNT_W'(r_i) == (r_total - CNT_W'(1)));
    assign last_j   = (CNT_W'(r_j) == (r_total - CNT_W'(1)));
    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        n_i         = r_i;
        n_j         = r_j;
        n_key_subj  = r_key_subj;
        n_key_pred  = r_key_pred;
        n_i_obj     = r_i_obj;
        n_i_tag     = r_i_tag;
        n_i_min     = r_i_min;
        n_found     = r_found;
        n_conflict  = r_conflict;
        n_best      = r_best;
        n_ans       = r_ans;
        n_via       = r_via;
        n_m1        = r_m1;
        n_m2        = r_m2;
        ram_we      = 1'b0;
        ram_raddr   = r_i;
        req_ready   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                req_ready = out_free;
                if (i_req.valid && out_free) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    unique case (i_req.req_type)
                        REQ_CLEAR: begin
                            n_total      = '0;
                            n_out.status = ST_STORED;
                        end
                        REQ_APPEND: begin
                            if (r_total == CNT_W'(MAX_EDGES)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                ram_we       = 1'b1;
                                n_total      = r_total + CNT_W'(1);
                                n_out.status = ST_STORED;
                            end
                        end
                        REQ_QUERY: begin
                            n_out.status = ST_UNRESOLVED;
                            if ((i_req.subject_id != '0) && (i_req.predicate_id != '0)
                                && (r_total != '0)) begin
                                // result comes later from the table walk
                                n_out_valid = r_out_valid && !o_rsp.ready;
                                n_out       = r_out;
                                n_key_subj  = i_req.subject_id;
                                n_key_pred  = i_req.predicate_id;
                                n_i         = '0;
                                n_found     = 1'b0;
                                n_conflict  = 1'b0;
                                n_state     = S_FETCH_I;
                            end
                        end
                        default: begin
                            n_out.status = ST_UNRESOLVED;
                        end
                    endcase
                end
            end

            S_FETCH_I: begin
                ram_raddr = r_i;
                n_state   = S_CHECK_I;
            end

            S_CHECK_I: begin
                if (hit_i) begin
                    n_i_obj   = rd.object;
                    n_i_tag   = rd.tag;
                    n_i_min   = j_min;
                    n_j       = '0;
                    ram_raddr = '0;
                    n_state   = S_SCAN;
                end else if (last_i) begin
                    n_state = S_DONE;
                end else begin
                    n_i       = r_i + IDX_W'(1);
                    ram_raddr = r_i + IDX_W'(1);
                end
            end

            S_SCAN: begin
                if (hit_j) begin
                    if (!r_found || (score > r_best)) begin
                        n_found    = 1'b1;
                        n_best     = score;
                        n_ans      = rd.object;
                        n_via      = r_i_obj;
                        n_m1       = r_i_tag;
                        n_m2       = rd.tag;
                        n_conflict = 1'b0;
                    end else if ((score == r_best) && (r_ans != rd.object)) begin
                        n_conflict = 1'b1;
                    end
                end
                if (last_j) begin
                    if (last_i) begin
                        n_state = S_DONE;
                    end else begin
                        n_i       = r_i + IDX_W'(1);
                        ram_raddr = r_i + IDX_W'(1);
                        n_state   = S_CHECK_I;
                    end
                end else begin
                    n_j       = r_j + IDX_W'(1);
                    ram_raddr = r_j + IDX_W'(1);
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    if (!r_found) begin
                        n_out.status = ST_UNRESOLVED;
                    end else if (r_conflict) begin
                        n_out.status     = ST_CONFLICT;
                        n_out.path_score = r_best;
                    end else begin
                        n_out.status          = ST_RESOLVED;
                        n_out.answer_id       = r_ans;
                        n_out.via_id          = r_via;
                        n_out.first_evidence  = r_m1;
                        n_out.second_evidence = r_m2;
                        n_out.path_score      = r_best;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_key_subj <= n_key_subj;
        r_key_pred <= n_key_pred;
        r_i_obj    <= n_i_obj;
        r_i_tag    <= n_i_tag;
        r_i_min    <= n_i_min;
        r_found    <= n_found;
        r_conflict <= n_conflict;
        r_best     <= n_best;
        r_ans      <= n_ans;
        r_via      <= n_via;
        r_m1       <= n_m1;
        r_m2       <= n_m2;
        r_out      <= n_out;
    end

    assign i_req.ready           = req_ready;
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.answer_id       = r_out.answer_id;
    assign o_rsp.via_id          = r_out.via_id;
    assign o_rsp.first_evidence  = r_out.first_evidence;
    assign o_rsp.second_evidence = r_out.second_evidence;
    assign o_rsp.path_score      = r_out.path_score;

endmodule

// File: src/thpr_ram.sv
// ============================================================================
// thpr_ram
// generic simple dual-port ram, one write and one registered read port
// ============================================================================
module thpr_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
